// ===== hdl/ipq_pkg.sv =====
package ipq_pkg;

    localparam logic [2:0] FN_PUSH     = 3'd0;
    localparam logic [2:0] FN_POP      = 3'd1;
    localparam logic [2:0] FN_REMOVE   = 3'd2;
    localparam logic [2:0] FN_CHANGE   = 3'd3;
    localparam logic [2:0] FN_CONTAINS = 3'd4;
    localparam logic [2:0] FN_CLEAR    = 3'd5;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_ABSENT  = 2'd1;
    localparam logic [1:0] ST_FULL    = 2'd2;
    localparam logic [1:0] ST_PRESENT = 2'd3;

    typedef enum logic [3:0] {
        S_IDLE,
        S_MAP_RD,
        S_HEAP_RD,
        S_POP_ROOT,
        S_POP_LAST,
        S_REM_LAST,
        S_UP_RD,
        S_UP_CMP,
        S_DN_L,
        S_DN_R,
        S_DN_CMP,
        S_WB,
        S_TOP_RD,
        S_DONE,
        S_INIT
    } ipq_state_t;

endpackage

// ===== hdl/ipq_ram.sv =====
module ipq_ram #(
    parameter int WIDTH = 42,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ===== hdl/indexed_min_priority_queue.sv =====
// Indexed min-priority queue: one operation per input beat (s_tuser carries the function code),
// one result beat per operation. Heap entries live in a CAPACITY-deep RAM and the key-to-slot
// map in a 2**KEY_BITS-deep RAM, both with registered reads and a single read port each.
// Contains, clear, rejected pushes and misses go from the map read and the heap read straight to
// the top read; a push or a priority decrease then climbs the heap, a pop or an increase descends
// it, and a remove of any slot but the last climbs or, if the moved entry does not rise, descends.
// The next beat is taken once the result has been handed to the result register. After reset
// the map RAM's 2**KEY_BITS entries (1024 by default) are swept to zero with s_tready held low.
// Clear only resets the count: every lookup is checked against the key stored in the heap slot.
module indexed_min_priority_queue #(
    parameter int CAPACITY      = 256,
    parameter int KEY_BITS      = 10,
    parameter int PRIORITY_BITS = 32
) (
    input  logic clk,
    input  logic rst_n,
    input  logic s_tvalid,
    output logic s_tready,
    input  logic [2:0] s_tuser,  // func
    input  logic [((KEY_BITS+PRIORITY_BITS+7)/8)*8-1:0] s_tdata,  // key, priority_req
    output logic m_tvalid,
    input  logic m_tready,
    // status, popped_key, popped_priority, top_key, top_priority, count
    output logic [((2+2*(KEY_BITS+PRIORITY_BITS)+$clog2(CAPACITY+1)+7)/8)*8-1:0] m_tdata
);
    import ipq_pkg::*;

    localparam int POS_W  = $clog2(CAPACITY + 1);
    localparam int ADDR_W = $clog2(CAPACITY);
    localparam int ENT_W  = KEY_BITS + PRIORITY_BITS;
    localparam int OUT_F  = 2 + 2 * ENT_W + POS_W;
    localparam int OUT_W  = ((OUT_F + 7) / 8) * 8;

    ipq_state_t state_reg, state_next;

    logic [2:0]               func_reg, func_next;
    logic [KEY_BITS-1:0]      key_reg, key_next;
    logic [PRIORITY_BITS-1:0] pri_reg, pri_next;
    logic [POS_W-1:0]         pos_reg, pos_next;
    logic [POS_W-1:0]         count_reg, count_next;
    logic [POS_W-1:0]         idx_reg, idx_next;
    logic [KEY_BITS-1:0]      cur_key_reg, cur_key_next;
    logic [PRIORITY_BITS-1:0] cur_pri_reg, cur_pri_next;
    logic [KEY_BITS-1:0]      lkey_reg, lkey_next;
    logic [PRIORITY_BITS-1:0] lpri_reg, lpri_next;
    logic                     moved_reg, moved_next;
    logic [1:0]               status_reg, status_next;
    logic [KEY_BITS-1:0]      pkey_reg, pkey_next;
    logic [PRIORITY_BITS-1:0] ppri_reg, ppri_next;
    logic                     ovalid_reg, ovalid_next;
    logic [OUT_W-1:0]         odata_reg, odata_next;
    logic [KEY_BITS-1:0]      clr_reg, clr_next;

    logic                     h_we, h_re, m_we, m_re;
    logic [ADDR_W-1:0]        h_waddr, h_raddr;
    logic [ENT_W-1:0]         h_wdata, h_rdata;
    logic [KEY_BITS-1:0]      m_waddr, m_raddr;
    logic [POS_W-1:0]         m_wdata, m_rdata;

    logic [KEY_BITS-1:0]      rd_key;
    logic [PRIORITY_BITS-1:0] rd_pri;
    logic [POS_W:0]           l_idx, r_idx, cnt_ext;
    logic                     l_ok, r_ok, hit, in_acc, out_free, up_less, sel_l, sel_r;
    logic                     go_down;
    logic [PRIORITY_BITS-1:0] best_pri;
    logic [KEY_BITS-1:0]      top_key;
    logic [PRIORITY_BITS-1:0] top_pri;

    function automatic logic [ADDR_W-1:0] slot(input logic [POS_W:0] p);
        logic [POS_W:0] t;
        t = p - 1'b1;
        return t[ADDR_W-1:0];
    endfunction

    function automatic logic less(input logic [PRIORITY_BITS-1:0] a,
                                  input logic [PRIORITY_BITS-1:0] b);
        return $signed(a) < $signed(b);
    endfunction

    ipq_ram #(.WIDTH(ENT_W), .DEPTH(CAPACITY)) u_heap (
        .clk   (clk),
        .we    (h_we),
        .waddr (h_waddr),
        .wdata (h_wdata),
        .re    (h_re),
        .raddr (h_raddr),
        .rdata (h_rdata)
    );

    ipq_ram #(.WIDTH(POS_W), .DEPTH(2 ** KEY_BITS)) u_map (
        .clk   (clk),
        .we    (m_we),
        .waddr (m_waddr),
        .wdata (m_wdata),
        .re    (m_re),
        .raddr (m_raddr),
        .rdata (m_rdata)
    );

    assign rd_key   = h_rdata[ENT_W-1 -: KEY_BITS];
    assign rd_pri   = h_rdata[PRIORITY_BITS-1:0];
    assign cnt_ext  = {1'b0, count_reg};
    assign l_idx    = {idx_reg, 1'b0};
    assign r_idx    = l_idx + 1'b1;
    assign l_ok     = l_idx <= cnt_ext;
    assign r_ok     = r_idx <= cnt_ext;
    assign hit      = (pos_reg != '0) && (pos_reg <= count_reg) && (rd_key == key_reg);
    assign in_acc   = s_tvalid && s_tready;
    assign out_free = !ovalid_reg || m_tready;
    assign up_less  = less(cur_pri_reg, rd_pri);
    assign sel_l    = less(lpri_reg, cur_pri_reg);
    assign best_pri = sel_l ? lpri_reg : cur_pri_reg;
    assign sel_r    = r_ok && less(rd_pri, best_pri);
    assign go_down  = !moved_reg && (func_reg == FN_REMOVE);
    assign top_key  = (count_reg != '0) ? rd_key : '0;
    assign top_pri  = (count_reg != '0) ? rd_pri : '0;

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = ovalid_reg;
    assign m_tdata  = odata_reg;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_INIT:     if (clr_reg == '1) state_next = S_IDLE;
            S_IDLE:     if (in_acc) state_next = S_MAP_RD;
            S_MAP_RD:   state_next = S_HEAP_RD;
            S_HEAP_RD:
            begin
                case (func_reg)
                    FN_PUSH:
                        state_next = (hit || count_reg == POS_W'(CAPACITY)) ? S_TOP_RD : S_UP_RD;
                    FN_POP:
                        state_next = (count_reg == '0) ? S_TOP_RD : S_POP_ROOT;
                    FN_REMOVE:
                        state_next = (!hit || pos_reg == count_reg) ? S_TOP_RD : S_REM_LAST;
                    FN_CHANGE:
                    begin
                        if (!hit)
                            state_next = S_TOP_RD;
                        else if (less(pri_reg, rd_pri))
                            state_next = S_UP_RD;
                        else if (less(rd_pri, pri_reg))
                            state_next = S_DN_L;
                        else
                            state_next = S_WB;
                    end
                    default:    state_next = S_TOP_RD;
                endcase
            end
            S_POP_ROOT: state_next = S_POP_LAST;
            S_POP_LAST: state_next = (count_reg == POS_W'(1)) ? S_TOP_RD : S_DN_L;
            S_REM_LAST: state_next = S_UP_RD;
            S_UP_RD:
            begin
                if (idx_reg == POS_W'(1))
                    state_next = go_down ? S_DN_L : S_WB;
                else
                    state_next = S_UP_CMP;
            end
            S_UP_CMP:
            begin
                if (up_less)
                    state_next = S_UP_RD;
                else
                    state_next = go_down ? S_DN_L : S_WB;
            end
            S_DN_L:     state_next = l_ok ? S_DN_R : S_WB;
            S_DN_R:     state_next = S_DN_CMP;
            S_DN_CMP:   state_next = (sel_l || sel_r) ? S_DN_L : S_WB;
            S_WB:       state_next = S_TOP_RD;
            S_TOP_RD:   state_next = S_DONE;
            S_DONE:     if (out_free) state_next = S_IDLE;
            default:    state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        func_next    = func_reg;
        key_next     = key_reg;
        pri_next     = pri_reg;
        pos_next     = pos_reg;
        count_next   = count_reg;
        idx_next     = idx_reg;
        cur_key_next = cur_key_reg;
        cur_pri_next = cur_pri_reg;
        lkey_next    = lkey_reg;
        lpri_next    = lpri_reg;
        moved_next   = moved_reg;
        status_next  = status_reg;
        pkey_next    = pkey_reg;
        ppri_next    = ppri_reg;
        ovalid_next  = ovalid_reg && !m_tready;
        odata_next   = odata_reg;
        clr_next     = clr_reg;
        h_we         = 1'b0;
        h_waddr      = slot({1'b0, idx_reg});
        h_wdata      = {cur_key_reg, cur_pri_reg};
        h_re         = 1'b0;
        h_raddr      = '0;
        m_we         = 1'b0;
        m_waddr      = cur_key_reg;
        m_wdata      = idx_reg;
        m_re         = 1'b0;
        m_raddr      = s_tdata[KEY_BITS-1:0];
        case (state_reg)
            S_INIT:
            begin
                m_we     = 1'b1;
                m_waddr  = clr_reg;
                m_wdata  = '0;
                clr_next = clr_reg + 1'b1;
            end
            S_IDLE:
            begin
                m_re = in_acc;
                if (in_acc)
                begin
                    func_next   = s_tuser;
                    key_next    = s_tdata[KEY_BITS-1:0];
                    pri_next    = s_tdata[ENT_W-1:KEY_BITS];
                    status_next = ST_OK;
                    pkey_next   = '0;
                    ppri_next   = '0;
                    moved_next  = 1'b0;
                end
            end
            S_MAP_RD:
            begin
                pos_next = m_rdata;
                h_re     = 1'b1;
                h_raddr  = slot({1'b0, m_rdata});
            end
            S_HEAP_RD:
            begin
                case (func_reg)
                    FN_PUSH:
                    begin
                        if (hit)
                            status_next = ST_PRESENT;
                        else if (count_reg == POS_W'(CAPACITY))
                            status_next = ST_FULL;
                        else
                        begin
                            count_next   = count_reg + 1'b1;
                            idx_next     = count_reg + 1'b1;
                            cur_key_next = key_reg;
                            cur_pri_next = pri_reg;
                        end
                    end
                    FN_POP:
                    begin
                        if (count_reg == '0)
                            status_next = ST_ABSENT;
                        h_re = 1'b1;
                    end
                    FN_REMOVE:
                    begin
                        if (!hit)
                            status_next = ST_ABSENT;
                        else
                        begin
                            m_we    = 1'b1;
                            m_waddr = key_reg;
                            m_wdata = '0;
                            idx_next = pos_reg;
                            if (pos_reg == count_reg)
                                count_next = count_reg - 1'b1;
                            h_re    = 1'b1;
                            h_raddr = slot({1'b0, count_reg});
                        end
                    end
                    FN_CHANGE:
                    begin
                        if (!hit)
                            status_next = ST_ABSENT;
                        moved_next   = 1'b1;
                        idx_next     = pos_reg;
                        cur_key_next = key_reg;
                        cur_pri_next = pri_reg;
                    end
                    FN_CONTAINS:
                        status_next = hit ? ST_OK : ST_ABSENT;
                    FN_CLEAR:
                        count_next = '0;
                    default: ;
                endcase
            end
            S_POP_ROOT:
            begin
                pkey_next = rd_key;
                ppri_next = rd_pri;
                m_we      = 1'b1;
                m_waddr   = rd_key;
                m_wdata   = '0;
                h_re      = 1'b1;
                h_raddr   = slot({1'b0, count_reg});
            end
            S_POP_LAST:
            begin
                cur_key_next = rd_key;
                cur_pri_next = rd_pri;
                count_next   = count_reg - 1'b1;
                idx_next     = POS_W'(1);
            end
            S_REM_LAST:
            begin
                cur_key_next = rd_key;
                cur_pri_next = rd_pri;
                count_next   = count_reg - 1'b1;
            end
            S_UP_RD:
            begin
                h_re    = 1'b1;
                h_raddr = slot({2'b00, idx_reg[POS_W-1:1]});
            end
            S_UP_CMP:
            begin
                if (up_less)
                begin
                    h_we       = 1'b1;
                    h_wdata    = h_rdata;
                    m_we       = 1'b1;
                    m_waddr    = rd_key;
                    idx_next   = {1'b0, idx_reg[POS_W-1:1]};
                    moved_next = 1'b1;
                end
            end
            S_DN_L:
            begin
                h_re    = l_ok;
                h_raddr = slot(l_idx);
            end
            S_DN_R:
            begin
                lkey_next = rd_key;
                lpri_next = rd_pri;
                h_re      = r_ok;
                h_raddr   = slot(r_idx);
            end
            S_DN_CMP:
            begin
                if (sel_r)
                begin
                    h_we     = 1'b1;
                    h_wdata  = h_rdata;
                    m_we     = 1'b1;
                    m_waddr  = rd_key;
                    idx_next = r_idx[POS_W-1:0];
                end
                else if (sel_l)
                begin
                    h_we     = 1'b1;
                    h_wdata  = {lkey_reg, lpri_reg};
                    m_we     = 1'b1;
                    m_waddr  = lkey_reg;
                    idx_next = l_idx[POS_W-1:0];
                end
            end
            S_WB:
            begin
                h_we = 1'b1;
                m_we = 1'b1;
            end
            S_TOP_RD:
            begin
                h_re = 1'b1;
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    ovalid_next = 1'b1;
                    odata_next  = OUT_W'({count_reg, top_pri, top_key, ppri_reg, pkey_reg,
                                          status_reg});
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_INIT;
            count_reg  <= '0;
            ovalid_reg <= 1'b0;
            clr_reg    <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            count_reg  <= count_next;
            ovalid_reg <= ovalid_next;
            clr_reg    <= clr_next;
        end
    end

    always_ff @(posedge clk)
    begin
        func_reg    <= func_next;
        key_reg     <= key_next;
        pri_reg     <= pri_next;
        pos_reg     <= pos_next;
        idx_reg     <= idx_next;
        cur_key_reg <= cur_key_next;
        cur_pri_reg <= cur_pri_next;
        lkey_reg    <= lkey_next;
        lpri_reg    <= lpri_next;
        moved_reg   <= moved_next;
        status_reg  <= status_next;
        pkey_reg    <= pkey_next;
        ppri_reg    <= ppri_next;
        odata_reg   <= odata_next;
    end

endmodule

// ===== hdl/ipq_checker.sv =====
module ipq_checker #(
    parameter int CAPACITY      = 256,
    parameter int KEY_BITS      = 10,
    parameter int PRIORITY_BITS = 32
) (
    input logic clk,
    input logic rst_n,
    input logic s_tvalid,
    input logic s_tready,
    input logic m_tvalid,
    input logic m_tready,
    input logic [((2+2*(KEY_BITS+PRIORITY_BITS)+$clog2(CAPACITY+1)+7)/8)*8-1:0] m_tdata
);
    localparam int POS_W   = $clog2(CAPACITY + 1);
    localparam int ENT_W   = KEY_BITS + PRIORITY_BITS;
    localparam int TOP_LSB = 2 + ENT_W;
    localparam int CNT_LSB = 2 + 2 * ENT_W;

    logic [POS_W-1:0] cnt;
    logic [ENT_W-1:0] top;

    assign cnt = m_tdata[CNT_LSB +: POS_W];
    assign top = m_tdata[TOP_LSB +: ENT_W];

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result beat dropped while stalled");

    a_stable: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> $stable(m_tdata))
        else $error("result beat changed while stalled");

    a_one_op: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("second beat taken before result");

    a_count: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> cnt <= POS_W'(CAPACITY))
        else $error("count beyond capacity");

    a_empty_top: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && cnt == '0 |-> top == '0)
        else $error("empty queue reports a top entry");

endmodule

bind indexed_min_priority_queue ipq_checker #(
    .CAPACITY      (CAPACITY),
    .KEY_BITS      (KEY_BITS),
    .PRIORITY_BITS (PRIORITY_BITS)
) u_ipq_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

// ===== dv/testbench.sv =====
module testbench;
    import ipq_pkg::*;

    localparam int CAP = 256;
    localparam int NKEYS = 1024;

    typedef struct packed {
        logic [2:0]  func;
        logic [9:0]  key;
        logic [31:0] pri;
    } op_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [9:0]  pkey;
        logic [31:0] ppri;
        logic [9:0]  tkey;
        logic [31:0] tpri;
        logic [8:0]  count;
    } res_t;

    typedef struct {
        op_t  op;
        bit   fixed;
        res_t res;
    } row_t;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [2:0]  s_tuser;
    logic [47:0] s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic [95:0] m_tdata;

    indexed_min_priority_queue u_dut (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tuser(s_tuser), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    logic [9:0]  hk [1:CAP];
    logic [31:0] hp [1:CAP];
    int          pmap [NKEYS];
    int          nheld;

    res_t queue_results[$];
    int   n_fail;
    int   send_idle_pct;
    int   recv_stall_pct;
    int   hold_cycles;

    function automatic bit lt(int i, int j);
        return $signed(hp[i]) < $signed(hp[j]);
    endfunction

    function automatic void swap_slots(int i, int j);
        logic [9:0]  k;
        logic [31:0] p;
        k = hk[i]; p = hp[i];
        hk[i] = hk[j]; hp[i] = hp[j];
        hk[j] = k; hp[j] = p;
        pmap[hk[i]] = i;
        pmap[hk[j]] = j;
    endfunction

    function automatic void sift_up(int i);
        while (i > 1 && lt(i, i / 2)) begin
            swap_slots(i, i / 2);
            i = i / 2;
        end
    endfunction

    function automatic void push_down(int i);
        int b;
        forever begin
            b = i;
            if (2 * i <= nheld && lt(2 * i, b)) b = 2 * i;
            if (2 * i + 1 <= nheld && lt(2 * i + 1, b)) b = 2 * i + 1;
            if (b == i) break;
            swap_slots(i, b);
            i = b;
        end
    endfunction

    function automatic res_t queue_apply(op_t op);
        res_t r;
        int pos;
        logic [31:0] old;
        r = '0;
        pos = pmap[op.key];
        if (pos > nheld) pos = 0;
        case (op.func)
            FN_PUSH:
                if (pos != 0) r.status = ST_PRESENT;
                else if (nheld >= CAP) r.status = ST_FULL;
                else begin
                    nheld++;
                    hk[nheld] = op.key; hp[nheld] = op.pri;
                    pmap[op.key] = nheld;
                    sift_up(nheld);
                end
            FN_POP:
                if (nheld == 0) r.status = ST_ABSENT;
                else begin
                    r.pkey = hk[1]; r.ppri = hp[1];
                    pmap[hk[1]] = 0;
                    if (nheld == 1) nheld = 0;
                    else begin
                        hk[1] = hk[nheld]; hp[1] = hp[nheld];
                        pmap[hk[1]] = 1;
                        nheld--;
                        push_down(1);
                    end
                end
            FN_REMOVE:
                if (pos == 0) r.status = ST_ABSENT;
                else begin
                    pmap[op.key] = 0;
                    if (pos == nheld) nheld--;
                    else begin
                        hk[pos] = hk[nheld]; hp[pos] = hp[nheld];
                        pmap[hk[pos]] = pos;
                        nheld--;
                        if (pos > 1 && lt(pos, pos / 2)) sift_up(pos);
                        else push_down(pos);
                    end
                end
            FN_CHANGE:
                if (pos == 0) r.status = ST_ABSENT;
                else begin
                    old = hp[pos];
                    hp[pos] = op.pri;
                    if ($signed(op.pri) < $signed(old)) sift_up(pos);
                    else if ($signed(old) < $signed(op.pri)) push_down(pos);
                end
            FN_CONTAINS: r.status = (pos != 0) ? ST_OK : ST_ABSENT;
            FN_CLEAR: begin
                for (int i = 1; i <= nheld; i++) pmap[hk[i]] = 0;
                nheld = 0;
            end
            default: ;
        endcase
        if (nheld != 0) begin
            r.tkey = hk[1];
            r.tpri = hp[1];
        end
        r.count = nheld[8:0];
        return r;
    endfunction

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #100000000;
        $display("Test completed with failures");
        $finish;
    end

    task automatic send_op(op_t op);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op.func;
        s_tdata  <= {6'd0, op.pri, op.key};
        @(posedge clk);
        while (!s_tready) @(posedge clk);
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (queue_results.size() != 0) @(posedge clk);
        repeat (40) @(posedge clk);
    endtask

    function automatic op_t rand_op(int keyspan, bit wide);
        op_t op;
        int r;
        r = $urandom_range(99);
        if (r < 45) op.func = FN_PUSH;
        else if (r < 70) op.func = FN_POP;
        else if (r < 80) op.func = FN_REMOVE;
        else if (r < 90) op.func = FN_CHANGE;
        else if (r < 97) op.func = FN_CONTAINS;
        else if (r < 99) op.func = FN_CLEAR;
        else op.func = 3'($urandom_range(7, 6));
        op.key = wide ? 10'($urandom) : 10'($urandom_range(keyspan - 1));
        op.pri = ($urandom_range(3) == 0) ? 32'($urandom) : 32'($signed($urandom_range(40)) - 20);
        return op;
    endfunction

    function automatic void push_check(op_t op, bit fixed, res_t want);
        res_t r;
        r = queue_apply(op);
        queue_results.push_back(fixed ? want : r);
    endfunction

    initial
    begin
        row_t rows[$];
        op_t op;
        res_t z;
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tuser = '0;
        s_tdata = '0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        hold_cycles = 0;
        n_fail = 0;
        nheld = 0;
        foreach (pmap[i]) pmap[i] = 0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        z = '0;
        rows.push_back('{'{FN_POP, 10'd0, 32'd0}, 1, '{ST_ABSENT, 0, 0, 0, 0, 0}});
        rows.push_back('{'{FN_CONTAINS, 10'd1023, 32'd0}, 1, '{ST_ABSENT, 0, 0, 0, 0, 0}});
        rows.push_back('{'{FN_REMOVE, 10'd5, 32'd0}, 1, '{ST_ABSENT, 0, 0, 0, 0, 0}});
        rows.push_back('{'{FN_CHANGE, 10'd5, 32'd7}, 1, '{ST_ABSENT, 0, 0, 0, 0, 0}});
        rows.push_back('{'{FN_PUSH, 10'd1023, 32'h7fffffff}, 1,
                         '{ST_OK, 0, 0, 10'd1023, 32'h7fffffff, 9'd1}});
        rows.push_back('{'{FN_PUSH, 10'd1023, 32'd0}, 1,
                         '{ST_PRESENT, 0, 0, 10'd1023, 32'h7fffffff, 9'd1}});
        rows.push_back('{'{FN_PUSH, 10'd0, 32'h80000000}, 1,
                         '{ST_OK, 0, 0, 10'd0, 32'h80000000, 9'd2}});
        rows.push_back('{'{FN_PUSH, 10'd341, 32'd5}, 0, z});
        rows.push_back('{'{FN_PUSH, 10'd682, 32'd5}, 0, z});
        rows.push_back('{'{FN_PUSH, 10'd7, 32'hffffffff}, 0, z});
        rows.push_back('{'{FN_CONTAINS, 10'd341, 32'd0}, 0, z});
        rows.push_back('{'{FN_CHANGE, 10'd1023, 32'h80000000}, 0, z});
        rows.push_back('{'{FN_CHANGE, 10'd0, 32'h7fffffff}, 0, z});
        rows.push_back('{'{FN_REMOVE, 10'd682, 32'd0}, 0, z});
        rows.push_back('{'{FN_POP, 10'd0, 32'd0}, 0, z});
        rows.push_back('{'{3'd6, 10'd3, 32'd3}, 0, z});
        rows.push_back('{'{3'd7, 10'd3, 32'd3}, 0, z});
        rows.push_back('{'{FN_CLEAR, 10'd0, 32'd0}, 1, '{ST_OK, 0, 0, 0, 0, 0}});
        rows.push_back('{'{FN_CONTAINS, 10'd7, 32'd0}, 1, '{ST_ABSENT, 0, 0, 0, 0, 0}});
        rows.push_back('{'{FN_POP, 10'd0, 32'd0}, 1, '{ST_ABSENT, 0, 0, 0, 0, 0}});
        foreach (rows[i])
        begin
            push_check(rows[i].op, rows[i].fixed, rows[i].res);
            send_op(rows[i].op);
        end
        drain();

        // fill to capacity, overflow, then empty again
        for (int i = 0; i < CAP + 2; i++)
        begin
            op.func = FN_PUSH;
            op.key = 10'(i * 3);
            op.pri = 32'($urandom);
            push_check(op, 0, z);
            send_op(op);
        end
        op = '{FN_PUSH, 10'd0, 32'd1};
        push_check(op, 0, z);
        send_op(op);
        hold_cycles = 400;
        for (int i = 0; i < 60; i++)
        begin
            op = rand_op(NKEYS, 1);
            push_check(op, 0, z);
            send_op(op);
        end
        for (int i = 0; i < CAP; i++)
        begin
            op = '{FN_POP, 10'd0, 32'd0};
            push_check(op, 0, z);
            send_op(op);
        end
        drain();

        for (int ph = 0; ph < 4; ph++)
        begin
            send_idle_pct  = (ph == 1 || ph == 3) ? ((ph == 3) ? 19 : 52) : 0;
            recv_stall_pct = (ph == 2 || ph == 3) ? ((ph == 3) ? 19 : 52) : 0;
            for (int i = 0; i < 400; i++)
            begin
                op = rand_op((ph % 2) ? 64 : 300, ($urandom_range(19) == 0));
                push_check(op, 0, z);
                send_op(op);
            end
            drain();
        end

        if (n_fail == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    initial
    begin
        m_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_cycles > 0)
            begin
                m_tready <= 1'b0;
                hold_cycles--;
            end
            else
                m_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge clk)
    begin
        res_t got;
        res_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            got.status = m_tdata[1:0];
            got.pkey   = m_tdata[11:2];
            got.ppri   = m_tdata[43:12];
            got.tkey   = m_tdata[53:44];
            got.tpri   = m_tdata[85:54];
            got.count  = m_tdata[94:86];
            if (queue_results.size() == 0)
            begin
                n_fail++;
                if (n_fail <= 10) $display("unexpected beat %h", got);
            end
            else
            begin
                want = queue_results.pop_front();
                if (got !== want)
                begin
                    n_fail++;
                    if (n_fail <= 10)
                        $display("mismatch: exp st=%0d pk=%0d pp=%h tk=%0d tp=%h n=%0d got st=%0d pk=%0d pp=%h tk=%0d tp=%h n=%0d",
                                 want.status, want.pkey, want.ppri, want.tkey, want.tpri,
                                 want.count, got.status, got.pkey, got.ppri, got.tkey,
                                 got.tpri, got.count);
                end
            end
        end
    end

endmodule
